>>> hw/rtl/csra_pkg.sv
// ----------------------------------------------------------------------------
// csra_pkg
// Shared types, field widths and codes for the contiguous slot range
// allocator.
// ----------------------------------------------------------------------------
package csra_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int OWNER_BITS_DEF = 22;

  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int IDX_FIELD_W = 7;
  localparam int CNT_W       = 7;
  localparam int MASK_W      = 64;

  localparam logic [MODE_W-1:0] MODE_MARK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QOWNER  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QCOUNT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // One slot of the first-fit scan
  typedef struct packed {
    logic             free;
    logic             at_end;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] longest;
  } step_in_t;

  typedef struct packed {
    logic             hit;
    logic             busy;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] longest;
  } step_out_t;

endpackage

>>> hw/rtl/csra_req_if.sv
// ----------------------------------------------------------------------------
// csra_req_if
// Request channel of the slot allocator: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface csra_req_if #(
  parameter int OWNER_BITS = csra_pkg::OWNER_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [csra_pkg::MODE_W-1:0]        mode;
  logic [OWNER_BITS-1:0]              requester;
  logic [csra_pkg::CNT_W-1:0]         count;
  logic [csra_pkg::IDX_FIELD_W-1:0]   start_index;
  logic [csra_pkg::IDX_FIELD_W-1:0]   end_index;
  logic [csra_pkg::MASK_W-1:0]        release_mask;

  modport source (
    output valid, mode, requester, count, start_index, end_index, release_mask,
    input  ready
  );
  modport sink (
    input  valid, mode, requester, count, start_index, end_index, release_mask,
    output ready
  );
endinterface

>>> hw/rtl/csra_rsp_if.sv
// ----------------------------------------------------------------------------
// csra_rsp_if
// Result channel of the slot allocator: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface csra_rsp_if #(
  parameter int OWNER_BITS = csra_pkg::OWNER_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [csra_pkg::STAT_W-1:0]   status;
  logic [csra_pkg::MASK_W-1:0]   granted_mask;
  logic [csra_pkg::CNT_W-1:0]    longest_free_run;
  logic [OWNER_BITS-1:0]         owner;
  logic [csra_pkg::CNT_W-1:0]    owned_count;

  modport source (
    output valid, status, granted_mask, longest_free_run, owner, owned_count,
    input  ready
  );
  modport sink (
    input  valid, status, granted_mask, longest_free_run, owner, owned_count,
    output ready
  );
endinterface

>>> hw/rtl/csra_ram.sv
// ----------------------------------------------------------------------------
// csra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/csra_step.sv
// ----------------------------------------------------------------------------
// csra_step
// Scan unit: examines one slot of the first-fit search and updates the
// current free run and the longest rejected run.
// ----------------------------------------------------------------------------
module csra_step (
  input  csra_pkg::step_in_t  step_in,
  output csra_pkg::step_out_t step_out
);

  logic [csra_pkg::CNT_W-1:0] run_inc;

  always_comb begin
    run_inc       = step_in.run + csra_pkg::CNT_W'(1);
    step_out.hit  = step_in.free &&
                    ((step_in.cnt == '0) || (run_inc == step_in.cnt));
    step_out.busy = step_in.at_end && !step_out.hit;
    if (step_in.free) begin
      step_out.run = run_inc;
      // a run cut off by the window end still counts as rejected
      if (step_in.at_end && !step_out.hit && (run_inc > step_in.longest)) begin
        step_out.longest = run_inc;
      end else begin
        step_out.longest = step_in.longest;
      end
    end else begin
      step_out.run = '0;
      if (step_in.run > step_in.longest) begin
        step_out.longest = step_in.run;
      end else begin
        step_out.longest = step_in.longest;
      end
    end
  end

endmodule

>>> hw/rtl/contiguous_slot_range_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_slot_range_allocator
// First-fit allocator of contiguous slot ranges with per-slot owner ids.
// ----------------------------------------------------------------------------
// Requests arrive on in_req (valid/ready); one result beat per request leaves
// on out_rsp (valid/ready). in_req.ready is high only while no request is in
// work. Slot owners live in a RAM; a flip-flop bit per slot marks it owned.
// Steps per request, from accept to the result register:
//   mark:        scan (at most end-start+1 slots), then write granted slots
//   release:     every slot, one slot read and compared per cycle
//   owner query: owner RAM read only for an owned slot
//   count query, bad bounds or zero requester: straight to the result
// Per cycle the scan examines one slot and the mark sweep writes one RAM entry.
// Reset clears all owned bits and the owned count at once; every slot reads
// as free right after reset, with no clearing pass.
// A finished result waits in the output register while out_rsp.ready is low;
// a second finished result waits inside the block, and no further request is
// taken until the output register drains.
// ----------------------------------------------------------------------------
module contiguous_slot_range_allocator #(
  parameter int SLOTS      = csra_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = csra_pkg::OWNER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  csra_req_if.sink   in_req,
  csra_rsp_if.source out_rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = csra_pkg::CNT_W;
  localparam int FW    = csra_pkg::IDX_FIELD_W;
  localparam int SW    = csra_pkg::STAT_W;

  localparam logic [FW-1:0]    SLOTS_F  = FW'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_MARK     = 3'd2;
  localparam logic [2:0] S_RLS      = 3'd3;
  localparam logic [2:0] S_RLS_TAIL = 3'd4;
  localparam logic [2:0] S_QRD      = 3'd5;
  localparam logic [2:0] S_QDATA    = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [IDX_W-1:0]      hi_r, hi_nxt;
  logic [IDX_W-1:0]      start_r, start_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [OWNER_BITS-1:0] who_r, who_nxt;
  logic [SLOTS-1:0]      mask_r, mask_nxt;
  logic [CW-1:0]         run_r, run_nxt;
  logic [CW-1:0]         longest_r, longest_nxt;
  logic [SLOTS-1:0]      owned_r, owned_nxt;
  logic [CW-1:0]         owned_cnt_r, owned_cnt_nxt;
  logic [SLOTS-1:0]      grant_r, grant_nxt;
  logic [SW-1:0]         status_r, status_nxt;
  logic [OWNER_BITS-1:0] own_res_r, own_res_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SW-1:0]         out_status_r, out_status_nxt;
  logic [SLOTS-1:0]      out_grant_r, out_grant_nxt;
  logic [CW-1:0]         out_longest_r, out_longest_nxt;
  logic [OWNER_BITS-1:0] out_owner_r, out_owner_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;

  logic                  ram_we;
  logic                  ram_re;
  logic [OWNER_BITS-1:0] ram_rdata;

  csra_pkg::step_in_t    step_in;
  csra_pkg::step_out_t   step_out;

  logic                  in_acc;
  logic                  lo_ok;
  logic                  hi_ok;
  logic                  win_ok;
  logic [IDX_W-1:0]      lo_idx;
  logic [IDX_W-1:0]      hi_idx;
  logic                  rls_hit;
  logic                  out_free;

  csra_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (SLOTS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (who_r),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  csra_step u_step (
    .step_in  (step_in),
    .step_out (step_out)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  assign lo_ok  = in_req.start_index < SLOTS_F;
  assign hi_ok  = in_req.end_index < SLOTS_F;
  assign win_ok = lo_ok && hi_ok && (in_req.start_index <= in_req.end_index);
  assign lo_idx = in_req.start_index[IDX_W-1:0];
  assign hi_idx = in_req.end_index[IDX_W-1:0];

  assign ram_we = (state_r == S_MARK);
  assign ram_re = (state_r == S_RLS) || (state_r == S_QRD);

  assign step_in.free    = !owned_r[ptr_r];
  assign step_in.at_end  = (ptr_r == hi_r);
  assign step_in.run     = run_r;
  assign step_in.cnt     = cnt_r;
  assign step_in.longest = longest_r;

  // compare the owner read for the slot checked last cycle
  assign rls_hit  = ((state_r == S_RLS) || (state_r == S_RLS_TAIL)) &&
                    chk_v_r && (ram_rdata == who_r);
  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    hi_nxt          = hi_r;
    start_nxt       = start_r;
    cnt_nxt         = cnt_r;
    who_nxt         = who_r;
    mask_nxt        = mask_r;
    run_nxt         = run_r;
    longest_nxt     = longest_r;
    owned_nxt       = owned_r;
    owned_cnt_nxt   = owned_cnt_r;
    grant_nxt       = grant_r;
    status_nxt      = status_r;
    own_res_nxt     = own_res_r;
    chk_v_nxt       = chk_v_r;
    chk_idx_nxt     = chk_idx_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_grant_nxt   = out_grant_r;
    out_longest_nxt = out_longest_r;
    out_owner_nxt   = out_owner_r;
    out_cnt_nxt     = out_cnt_r;

    if (rls_hit) begin
      owned_nxt[chk_idx_r] = 1'b0;
      owned_cnt_nxt        = owned_cnt_r - CW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          who_nxt     = in_req.requester;
          cnt_nxt     = in_req.count;
          mask_nxt    = in_req.release_mask[SLOTS-1:0];
          grant_nxt   = '0;
          longest_nxt = '0;
          run_nxt     = '0;
          own_res_nxt = '0;
          status_nxt  = csra_pkg::ST_OK;
          chk_v_nxt   = 1'b0;
          state_nxt   = S_EMIT;
          case (in_req.mode)
            csra_pkg::MODE_MARK: begin
              if ((in_req.requester == '0) || !win_ok) begin
                status_nxt = csra_pkg::ST_INVALID;
              end else begin
                ptr_nxt   = lo_idx;
                hi_nxt    = hi_idx;
                start_nxt = lo_idx;
                state_nxt = S_SCAN;
              end
            end
            csra_pkg::MODE_RELEASE: begin
              ptr_nxt   = '0;
              state_nxt = S_RLS;
            end
            csra_pkg::MODE_QOWNER: begin
              if (!lo_ok) begin
                status_nxt = csra_pkg::ST_NOT_FOUND;
              end else if (owned_r[lo_idx]) begin
                ptr_nxt   = lo_idx;
                state_nxt = S_QRD;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        run_nxt     = step_out.run;
        longest_nxt = step_out.longest;
        ptr_nxt     = ptr_r + IDX_W'(1);
        if (step_in.free && (run_r == '0)) begin
          start_nxt = ptr_r;
        end
        if (step_out.hit) begin
          if (cnt_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            // sweep the run from its first slot up to this one
            ptr_nxt   = (run_r == '0) ? ptr_r : start_r;
            hi_nxt    = ptr_r;
            state_nxt = S_MARK;
          end
        end else if (step_out.busy) begin
          status_nxt = csra_pkg::ST_BUSY;
          state_nxt  = S_EMIT;
        end
      end
      S_MARK: begin
        owned_nxt[ptr_r] = 1'b1;
        grant_nxt[ptr_r] = 1'b1;
        owned_cnt_nxt    = owned_cnt_r + CW'(1);
        ptr_nxt          = ptr_r + IDX_W'(1);
        if (ptr_r == hi_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_RLS: begin
        chk_v_nxt   = mask_r[ptr_r] && owned_r[ptr_r];
        chk_idx_nxt = ptr_r;
        ptr_nxt     = ptr_r + IDX_W'(1);
        if (ptr_r == LAST_IDX) begin
          state_nxt = S_RLS_TAIL;
        end
      end
      S_RLS_TAIL: begin
        chk_v_nxt = 1'b0;
        state_nxt = S_EMIT;
      end
      S_QRD: begin
        state_nxt = S_QDATA;
      end
      S_QDATA: begin
        own_res_nxt = ram_rdata;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_grant_nxt   = grant_r;
          out_longest_nxt = longest_r;
          out_owner_nxt   = own_res_r;
          out_cnt_nxt     = owned_cnt_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      owned_r     <= '0;
      owned_cnt_r <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      owned_r     <= owned_nxt;
      owned_cnt_r <= owned_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    hi_r          <= hi_nxt;
    start_r       <= start_nxt;
    cnt_r         <= cnt_nxt;
    who_r         <= who_nxt;
    mask_r        <= mask_nxt;
    run_r         <= run_nxt;
    longest_r     <= longest_nxt;
    grant_r       <= grant_nxt;
    status_r      <= status_nxt;
    own_res_r     <= own_res_nxt;
    chk_idx_r     <= chk_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_grant_r   <= out_grant_nxt;
    out_longest_r <= out_longest_nxt;
    out_owner_r   <= out_owner_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.status           = out_status_r;
  assign out_rsp.granted_mask     = csra_pkg::MASK_W'(out_grant_r);
  assign out_rsp.longest_free_run = out_longest_r;
  assign out_rsp.owner            = out_owner_r;
  assign out_rsp.owned_count      = out_cnt_r;

`ifndef SYNTHESIS
  // the owned count tracks the owned bits
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    owned_cnt_r == CW'($countones(owned_r)))
    else $error("owned count out of step with owned bits");

  // a result other than ok never carries a grant
  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != csra_pkg::ST_OK) |-> out_grant_r == '0)
    else $error("grant mask on a failed request");

  // every granted slot of a finished mark is owned
  a_grant_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (grant_r & ~owned_r) == '0)
    else $error("granted slot not owned");

  // the scan stays inside the window
  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) || (state_r == S_MARK) |-> ptr_r <= hi_r)
    else $error("scan pointer past window end");

  // a pending release check refers to an owned slot
  a_chk_owned: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> owned_r[chk_idx_r])
    else $error("release check on a free slot");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit contiguous slot range allocator.
// Requests are driven from a backlog, and a slot-ownership shadow predicts
// each response. The monitor compares every response beat field by field.
// The stimulus is a directed opening followed by about 500 random requests,
// with random idling, one long response stall and drained pauses.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = csra_pkg::SLOTS_DEF;
  localparam int OWNER_BITS  = csra_pkg::OWNER_BITS_DEF;
  localparam int RANDOM_REQS = 500;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 100;
  localparam int SETTLE      = 2 * SLOTS + 20;

  typedef struct {
    logic [csra_pkg::MODE_W-1:0]      mode;
    logic [OWNER_BITS-1:0]            requester;
    logic [csra_pkg::CNT_W-1:0]       count;
    logic [csra_pkg::IDX_FIELD_W-1:0] start_index;
    logic [csra_pkg::IDX_FIELD_W-1:0] end_index;
    logic [csra_pkg::MASK_W-1:0]      release_mask;
    bit                               no_gap;
    bit                               drain_first;
  } alloc_req_t;

  typedef struct {
    logic [csra_pkg::STAT_W-1:0] status;
    logic [csra_pkg::MASK_W-1:0] granted_mask;
    logic [csra_pkg::CNT_W-1:0]  longest_free_run;
    logic [OWNER_BITS-1:0]       owner;
    logic [csra_pkg::CNT_W-1:0]  owned_count;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  csra_req_if #(.OWNER_BITS(OWNER_BITS)) req_ch ();
  csra_rsp_if #(.OWNER_BITS(OWNER_BITS)) rsp_ch ();

  contiguous_slot_range_allocator #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alloc_req_t            req_backlog[$];
  alloc_rsp_t            predicted_rsp[$];
  logic [OWNER_BITS-1:0] slot_owner_m[SLOTS];
  int                    owned_m;
  int                    n_sent;
  int                    n_recv;
  int                    mismatches;
  int                    stall_cycles;
  int                    hold_left;
  bit                    hold_done;
  int                    n_granted, n_busy, n_invalid, n_release, n_query, peak_owned;

  // Shadow of the slot table: apply one request, return its response
  function automatic alloc_rsp_t allocate_model(
    logic [csra_pkg::MODE_W-1:0] mode, logic [OWNER_BITS-1:0] who,
    logic [csra_pkg::CNT_W-1:0] cnt, logic [csra_pkg::IDX_FIELD_W-1:0] lo,
    logic [csra_pkg::IDX_FIELD_W-1:0] hi, logic [csra_pkg::MASK_W-1:0] rmask);
    alloc_rsp_t r;
    int         i, j, run, lo_i, hi_i, cnt_i;
    bit         done;
    r.status           = csra_pkg::ST_OK;
    r.granted_mask     = '0;
    r.longest_free_run = '0;
    r.owner            = '0;
    lo_i  = int'(lo);
    hi_i  = int'(hi);
    cnt_i = int'(cnt);
    case (mode)
      csra_pkg::MODE_MARK: begin
        if (who == 0 || lo_i > hi_i || lo_i >= SLOTS || hi_i >= SLOTS) begin
          r.status = csra_pkg::ST_INVALID;
          n_invalid++;
        end else begin
          r.status = csra_pkg::ST_BUSY;
          i = lo_i;
          done = 1'b0;
          while (i <= hi_i && !done) begin
            if (slot_owner_m[i] != 0) begin
              i++;
            end else begin
              run = 0;
              j = i;
              while (j <= hi_i && j < i + cnt_i && slot_owner_m[j] == 0) begin
                run = j - i + 1;
                j++;
              end
              if (cnt_i == 0) run = 1;
              if (run >= cnt_i) begin
                for (j = i; j < i + cnt_i; j++) begin
                  slot_owner_m[j]   = who;
                  r.granted_mask[j] = 1'b1;
                  owned_m++;
                end
                r.status = csra_pkg::ST_OK;
                done = 1'b1;
              end else begin
                if (int'(r.longest_free_run) < run) begin
                  r.longest_free_run = csra_pkg::CNT_W'(run);
                end
                // resume right after the slot that ended the run
                i = j + 1;
              end
            end
          end
          if (done) n_granted++;
          else n_busy++;
        end
      end
      csra_pkg::MODE_RELEASE: begin
        n_release++;
        for (i = 0; i < SLOTS; i++) begin
          if (rmask[i] && slot_owner_m[i] != 0 && slot_owner_m[i] == who) begin
            slot_owner_m[i] = '0;
            if (owned_m > 0) owned_m--;
          end
        end
      end
      csra_pkg::MODE_QOWNER: begin
        n_query++;
        if (lo_i >= SLOTS) r.status = csra_pkg::ST_NOT_FOUND;
        else r.owner = slot_owner_m[lo_i];
      end
      default: n_query++;
    endcase
    if (owned_m > peak_owned) peak_owned = owned_m;
    r.owned_count = csra_pkg::CNT_W'(owned_m);
    return r;
  endfunction

  task automatic queue_req(logic [csra_pkg::MODE_W-1:0] mode, int who, int cnt,
                           int lo, int hi, logic [csra_pkg::MASK_W-1:0] rmask);
    alloc_req_t q;
    q.mode         = mode;
    q.requester    = OWNER_BITS'(who);
    q.count        = csra_pkg::CNT_W'(cnt);
    q.start_index  = csra_pkg::IDX_FIELD_W'(lo);
    q.end_index    = csra_pkg::IDX_FIELD_W'(hi);
    q.release_mask = rmask;
    q.no_gap       = 1'b0;
    q.drain_first  = 1'b0;
    req_backlog.push_back(q);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: predict on accept, then offer the next backlog entry
  always @(posedge clk) begin
    bit         taken;
    alloc_req_t nxt;
    if (rst_n) begin
      taken = req_ch.valid && req_ch.ready;
      if (taken) begin
        predicted_rsp.push_back(allocate_model(req_ch.mode, req_ch.requester,
                                               req_ch.count, req_ch.start_index,
                                               req_ch.end_index, req_ch.release_mask));
        n_sent <= n_sent + 1;
      end
      if (!req_ch.valid || taken) begin
        if (req_backlog.size() != 0 &&
            (!req_backlog[0].drain_first || n_sent + int'(taken) == n_recv) &&
            (req_backlog[0].no_gap || $urandom_range(0, 99) >= 6)) begin
          nxt = req_backlog.pop_front();
          req_ch.mode         <= nxt.mode;
          req_ch.requester    <= nxt.requester;
          req_ch.count        <= nxt.count;
          req_ch.start_index  <= nxt.start_index;
          req_ch.end_index    <= nxt.end_index;
          req_ch.release_mask <= nxt.release_mask;
          req_ch.valid        <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready generator
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_recv <= n_recv + 1;
        if (predicted_rsp.size() == 0) begin
          $display("%0t: response beat with nothing outstanding, status %h", $time,
                   rsp_ch.status);
          mismatches++;
        end else begin
          want = predicted_rsp.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_ch.status));
          check_field("granted_mask", want.granted_mask, rsp_ch.granted_mask);
          check_field("longest_free_run", 64'(want.longest_free_run),
                      64'(rsp_ch.longest_free_run));
          check_field("owner", 64'(want.owner), 64'(rsp_ch.owner));
          check_field("owned_count", 64'(want.owned_count), 64'(rsp_ch.owned_count));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && n_recv == HOLD_AT) begin
        // hold off long enough for the block to back up into its input
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (n_recv >= 270 && n_recv < 370) || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    alloc_req_t q;
    int         total, r, len, base;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = csra_pkg::MODE_QCOUNT;
    req_ch.requester    = '0;
    req_ch.count        = '0;
    req_ch.start_index  = '0;
    req_ch.end_index    = '0;
    req_ch.release_mask = '0;
    rsp_ch.ready        = 1'b0;
    n_sent = 0; n_recv = 0; mismatches = 0; stall_cycles = 0;
    hold_left = 0; hold_done = 1'b0; owned_m = 0;
    n_granted = 0; n_busy = 0; n_invalid = 0; n_release = 0; n_query = 0;
    peak_owned = 0;
    for (int i = 0; i < SLOTS; i++) slot_owner_m[i] = '0;

    // directed opening
    queue_req(csra_pkg::MODE_QCOUNT, 0, 0, 0, 0, 0);
    queue_req(csra_pkg::MODE_QOWNER, 7, 0, 0, 0, 0);
    queue_req(csra_pkg::MODE_QOWNER, 7, 0, 63, 0, 0);
    queue_req(csra_pkg::MODE_QOWNER, 7, 0, 64, 0, 0);          // index past the table
    queue_req(csra_pkg::MODE_QOWNER, '1, '1, 127, 127, '1);
    queue_req(csra_pkg::MODE_MARK, 0, 1, 0, 63, 0);            // zero requester
    queue_req(csra_pkg::MODE_MARK, 1, 1, 10, 9, 0);            // inverted window
    queue_req(csra_pkg::MODE_MARK, 1, 1, 64, 127, 0);
    queue_req(csra_pkg::MODE_MARK, 1, 1, 0, 64, 0);
    queue_req(csra_pkg::MODE_MARK, 1, 0, 0, 63, 0);            // zero count, empty table
    queue_req(csra_pkg::MODE_MARK, 1, 64, 0, 63, 0);           // whole table
    queue_req(csra_pkg::MODE_QCOUNT, 0, 0, 0, 0, 0);
    queue_req(csra_pkg::MODE_MARK, 2, 0, 0, 63, 0);            // zero count, nothing free
    queue_req(csra_pkg::MODE_RELEASE, 2, 0, 0, 0, '1);         // not the owner
    queue_req(csra_pkg::MODE_RELEASE, 1, 0, 0, 0, '1);
    queue_req(csra_pkg::MODE_MARK, 1, 65, 0, 63, 0);           // more than the table holds
    queue_req(csra_pkg::MODE_MARK, 1, 127, 0, 63, 0);
    queue_req(csra_pkg::MODE_MARK, 5, 1, 3, 3, 0);
    queue_req(csra_pkg::MODE_MARK, 6, 2, 0, 1, 0);
    queue_req(csra_pkg::MODE_MARK, 7, 3, 0, 10, 0);            // gap at 2, resume past slot 3
    queue_req(csra_pkg::MODE_MARK, '1, 5, 60, 63, 0);          // short run at the top
    queue_req(csra_pkg::MODE_MARK, '1, 4, 60, 63, 0);
    queue_req(csra_pkg::MODE_QOWNER, 0, 0, 63, 0, 0);
    queue_req(csra_pkg::MODE_RELEASE, 0, 0, 0, 0, '1);         // zero requester frees nothing
    queue_req(csra_pkg::MODE_RELEASE, '1, 0, 0, 0, 64'hF000_0000_0000_0000);

    // random part: mostly well-formed requests from a small owner pool
    for (int k = 0; k < RANDOM_REQS; k++) begin
      q.mode         = csra_pkg::MODE_W'($urandom_range(0, 3));
      q.requester    = OWNER_BITS'($urandom());
      q.count        = csra_pkg::CNT_W'($urandom());
      q.start_index  = csra_pkg::IDX_FIELD_W'($urandom());
      q.end_index    = csra_pkg::IDX_FIELD_W'($urandom());
      q.release_mask = {$urandom(), $urandom()};
      r = $urandom_range(0, 99);
      if (r < 45) q.mode = csra_pkg::MODE_MARK;
      else if (r < 70) q.mode = csra_pkg::MODE_RELEASE;
      else if (r < 90) q.mode = csra_pkg::MODE_QOWNER;
      else q.mode = csra_pkg::MODE_QCOUNT;
      r = $urandom_range(0, 99);
      if (r < 3) q.requester = '0;
      else if (r < 88) q.requester = OWNER_BITS'($urandom_range(1, 6));
      if (q.mode == csra_pkg::MODE_MARK) begin
        r = $urandom_range(0, 99);
        if (r < 60) q.count = csra_pkg::CNT_W'($urandom_range(0, 6));
        else if (r < 85) q.count = csra_pkg::CNT_W'($urandom_range(7, 20));
        else if (r < 95) q.count = csra_pkg::CNT_W'($urandom_range(21, 64));
        r = $urandom_range(0, 99);
        if (r < 30) begin
          q.start_index = '0;
          q.end_index   = csra_pkg::IDX_FIELD_W'(SLOTS - 1);
        end else if (r < 85) begin
          q.start_index = csra_pkg::IDX_FIELD_W'($urandom_range(0, SLOTS - 1));
          q.end_index   = csra_pkg::IDX_FIELD_W'($urandom_range(q.start_index,
                                                                SLOTS - 1));
        end
      end else if (q.mode == csra_pkg::MODE_RELEASE) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          len  = $urandom_range(1, 16);
          base = $urandom_range(0, SLOTS - len);
          q.release_mask = ({csra_pkg::MASK_W{1'b1}} >> (csra_pkg::MASK_W - len)) << base;
        end else if (r < 45) begin
          q.release_mask = '1;
        end else if (r < 60) begin
          q.release_mask = 64'h1 << $urandom_range(0, 63);
        end
      end else if (q.mode == csra_pkg::MODE_QOWNER) begin
        if ($urandom_range(0, 9) != 0) begin
          q.start_index = csra_pkg::IDX_FIELD_W'($urandom_range(0, SLOTS - 1));
        end
      end
      q.no_gap      = (k >= 250 && k < 350);
      q.drain_first = (k == 0 || k == 150 || k == 400);
      req_backlog.push_back(q);
    end
    total = req_backlog.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < total || n_recv < n_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests: %0d grants, %0d busy, %0d invalid marks,",
             n_sent, n_granted, n_busy, n_invalid);
    $display("  %0d releases, %0d queries, peak of %0d owned slots",
             n_release, n_query, peak_owned);
    if (mismatches == 0 && predicted_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/csra_pkg.sv
hw/rtl/csra_req_if.sv
hw/rtl/csra_rsp_if.sv
hw/rtl/csra_ram.sv
hw/rtl/csra_step.sv
hw/rtl/contiguous_slot_range_allocator.sv
test/tb_top.sv
